/* hdl/lbfgs_pkg.sv */
// Shared types, codes and helpers for the L-BFGS correction update core.
package lbfgs_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_LENGTH    = 2'd0;
  localparam logic [1:0] REG_DEPTH     = 2'd1;
  localparam logic [1:0] REG_TOLERANCE = 2'd2;

  // Accumulator slots of the shared multiply-accumulate unit
  typedef enum logic [1:0] {
    ACC_YY = 2'd0,
    ACC_SY = 2'd1,
    ACC_SS = 2'd2
  } acc_sel_t;

  // Control request from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic     issue;  // register a new product
    logic     accum;  // add that product into an accumulator next cycle
    acc_sel_t sel;
    logic     clear;  // zero all accumulators
  } mac_ctl_t;

  // Signed 64-bit add that clamps at the range limits
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = s[63:0];
    end
  endfunction

endpackage

/* hdl/lbfgs_ram.sv */
// Generic simple dual-port RAM with registered read.
module lbfgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/lbfgs_mac.sv */
// Shared multiplier with three saturating Q32.32 accumulators.
module lbfgs_mac (
  input  logic                    clk,
  input  logic                    rst,
  input  lbfgs_pkg::mac_ctl_t     ctl,
  input  logic signed [32:0]      op_a,
  input  logic signed [32:0]      op_b,
  output logic signed [65:0]      prod,
  output logic signed [63:0]      acc_yy,
  output logic signed [63:0]      acc_sy,
  output logic signed [63:0]      acc_ss
);

  logic                pend;
  lbfgs_pkg::acc_sel_t sel_r;

  // Product register
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod  <= op_a * op_b;
      sel_r <= ctl.sel;
    end
  end

  // Accumulate in the cycle after the product lands
  always_ff @(posedge clk) begin
    if (rst) begin
      pend   <= 1'b0;
      acc_yy <= '0;
      acc_sy <= '0;
      acc_ss <= '0;
    end else begin
      pend <= ctl.issue & ctl.accum;
      if (ctl.clear) begin
        acc_yy <= '0;
        acc_sy <= '0;
        acc_ss <= '0;
      end else if (pend) begin
        case (sel_r)
          lbfgs_pkg::ACC_YY: acc_yy <= lbfgs_pkg::sat_add(acc_yy, prod[63:0]);
          lbfgs_pkg::ACC_SY: acc_sy <= lbfgs_pkg::sat_add(acc_sy, prod[63:0]);
          lbfgs_pkg::ACC_SS: acc_ss <= lbfgs_pkg::sat_add(acc_ss, prod[63:0]);
          default: ;
        endcase
      end
    end
  end

endmodule

/* hdl/lbfgs_div.sv */
// Bit-serial restoring divider for theta = y'y / s'y in saturated Q16.16.
module lbfgs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [31:0] quo
);

  logic        busy;
  logic [6:0]  cnt;
  logic [79:0] dividend;
  logic [79:0] q;
  logic [64:0] rem;
  logic [64:0] r1;
  logic        fits;

  // One quotient bit per cycle
  always_comb begin
    r1   = {rem[63:0], dividend[79]};
    fits = (r1 >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= 7'd80;
        dividend <= {num, 16'd0};
        rem      <= '0;
        q        <= '0;
      end else if (busy) begin
        dividend <= {dividend[78:0], 1'b0};
        rem      <= fits ? (r1 - {1'b0, den}) : r1;
        q        <= {q[78:0], fits};
        cnt      <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Saturate when the quotient needs more than 32 bits
  assign quo = (q[79:32] != '0) ? 32'hFFFF_FFFF : q[31:0];

endmodule

/* hdl/limited_memory_bfgs_update_core.sv */
// Top level of the L-BFGS correction update core.
// Takes one element pair (s, y) per request, using one shared multiplier that forms
// y*y, s*y and s*s in turn. The last element of a vector starts the update: the
// curvature test (a failing pair gives one zeroed result), ring pointer reduction,
// a copy of the staged pair into the column store, the theta divider, then for
// each older column a pass of the same multiplier (s.y_j then s_j.s per element),
// one result as each finishes, and a last result with s'y and s's. Results wait
// in an output register; no new element is taken until the whole run has been
// delivered.
module limited_memory_bfgs_update_core #(
  parameter int MAX_HISTORY = 8,
  parameter int MAX_LENGTH  = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] step_value,
  input  logic signed [31:0] grad_diff_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               accepted,
  output logic [31:0]        theta,
  output logic [2:0]         row_position,
  output logic signed [63:0] sy_entry,
  output logic signed [63:0] ss_entry,
  output logic               last_result
);

  localparam int IW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LW = $clog2(MAX_LENGTH + 1);
  localparam int HW = $clog2(MAX_HISTORY + 1);
  localparam int PW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
  localparam int UW = $clog2(MAX_HISTORY + 2);
  localparam int CD = MAX_LENGTH * MAX_HISTORY;
  localparam int CW = $clog2(CD);

  typedef enum logic [4:0] {
    S_IDLE, S_EL_SY, S_EL_SS, S_EL_WAIT, S_SNAP, S_THR2, S_THR3, S_RED, S_RING,
    S_COPY, S_DIV_GO, S_DIV_WAIT, S_X_ADDR, S_X_MA, S_X_MB, S_X_DRAIN, S_X_EMIT,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers
  logic [12:0] vector_length;
  logic [3:0]  history_depth;
  logic [31:0] curvature_tolerance;

  // Run state
  logic [IW-1:0]      element_count;
  logic               last_el;
  logic signed [31:0] sv, yv;
  logic signed [63:0] rr, dr, sss;
  logic [63:0]        p1;
  logic [HW-1:0]      filled_columns, col, j;
  logic [PW-1:0]      oldest_column, newest_column, hr, nr, tail, ptr;
  logic [UW-1:0]      update_count;
  logic [LW-1:0]      ci, xi;

  logic [LW-1:0] n_eff;
  logic [HW-1:0] m_eff;
  logic          in_acc;
  logic          is_last;

  // Effective length and depth after clamping
  always_comb begin
    if (vector_length == '0) begin
      n_eff = LW'(1);
    end else if (32'(vector_length) > 32'(MAX_LENGTH)) begin
      n_eff = LW'(MAX_LENGTH);
    end else begin
      n_eff = LW'(vector_length);
    end
    if (history_depth == '0) begin
      m_eff = HW'(1);
    end else if (32'(history_depth) > 32'(MAX_HISTORY)) begin
      m_eff = HW'(MAX_HISTORY);
    end else begin
      m_eff = HW'(history_depth);
    end
  end

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign is_last  = (LW'(element_count) + LW'(1) >= n_eff);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length       <= 13'd1;
      history_depth       <= 4'd8;
      curvature_tolerance <= 32'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        lbfgs_pkg::REG_LENGTH:    vector_length       <= cfg_data[12:0];
        lbfgs_pkg::REG_DEPTH:     history_depth       <= cfg_data[3:0];
        lbfgs_pkg::REG_TOLERANCE: curvature_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memories
  logic [LW-1:0] rd_i;
  logic [IW-1:0] stg_raddr;
  logic [CW-1:0] col_raddr, col_waddr;
  logic          col_we;
  logic [31:0]   s_stg, y_stg, s_col, y_col;

  assign rd_i      = (state == S_X_MB) ? (xi + LW'(1)) : xi;
  assign stg_raddr = (state == S_COPY) ? IW'(ci) : IW'(rd_i);
  assign col_raddr = CW'(IW'(rd_i)) * CW'(MAX_HISTORY) + CW'(ptr);
  assign col_we    = (state == S_COPY) && (ci != '0);
  assign col_waddr = CW'(IW'(ci - LW'(1))) * CW'(MAX_HISTORY) + CW'(tail);

  lbfgs_ram #(.WIDTH(32), .DEPTH(MAX_LENGTH)) u_step_staging (
    .clk(clk), .we(in_acc), .waddr(element_count), .wdata(step_value),
    .raddr(stg_raddr), .rdata(s_stg));
  lbfgs_ram #(.WIDTH(32), .DEPTH(MAX_LENGTH)) u_grad_staging (
    .clk(clk), .we(in_acc), .waddr(element_count), .wdata(grad_diff_value),
    .raddr(stg_raddr), .rdata(y_stg));
  lbfgs_ram #(.WIDTH(32), .DEPTH(CD)) u_step_columns (
    .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(s_stg),
    .raddr(col_raddr), .rdata(s_col));
  lbfgs_ram #(.WIDTH(32), .DEPTH(CD)) u_grad_columns (
    .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(y_stg),
    .raddr(col_raddr), .rdata(y_col));

  // Shared multiply-accumulate
  lbfgs_pkg::mac_ctl_t mac_ctl;
  logic signed [32:0]  op_a, op_b;
  logic signed [65:0]  prod;
  logic signed [63:0]  acc_yy, acc_sy, acc_ss;

  always_comb begin
    mac_ctl = '{issue: 1'b0, accum: 1'b0, sel: lbfgs_pkg::ACC_YY, clear: 1'b0};
    op_a    = '0;
    op_b    = '0;
    case (state)
      S_IDLE: begin
        mac_ctl.issue = in_acc;
        mac_ctl.accum = 1'b1;
        op_a = {grad_diff_value[31], grad_diff_value};
        op_b = {grad_diff_value[31], grad_diff_value};
      end
      S_EL_SY: begin
        mac_ctl = '{issue: 1'b1, accum: 1'b1, sel: lbfgs_pkg::ACC_SY, clear: 1'b0};
        op_a = {sv[31], sv};
        op_b = {yv[31], yv};
      end
      S_EL_SS: begin
        mac_ctl = '{issue: 1'b1, accum: 1'b1, sel: lbfgs_pkg::ACC_SS, clear: 1'b0};
        op_a = {sv[31], sv};
        op_b = {sv[31], sv};
      end
      S_SNAP: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        op_a = {1'b0, curvature_tolerance};
        op_b = {1'b0, acc_yy[63:32]};
      end
      S_THR2: begin
        mac_ctl.issue = 1'b1;
        op_a = {1'b0, curvature_tolerance};
        op_b = {1'b0, rr[31:0]};
      end
      S_X_MA: begin
        mac_ctl = '{issue: 1'b1, accum: 1'b1, sel: lbfgs_pkg::ACC_SY, clear: 1'b0};
        op_a = {s_stg[31], s_stg};
        op_b = {y_col[31], y_col};
      end
      S_X_MB: begin
        mac_ctl = '{issue: 1'b1, accum: 1'b1, sel: lbfgs_pkg::ACC_SS, clear: 1'b0};
        op_a = {s_col[31], s_col};
        op_b = {s_stg[31], s_stg};
      end
      S_X_EMIT: mac_ctl.clear = 1'b1;
      default: ;
    endcase
  end

  lbfgs_mac u_mac (
    .clk(clk), .rst(rst), .ctl(mac_ctl), .op_a(op_a), .op_b(op_b), .prod(prod),
    .acc_yy(acc_yy), .acc_sy(acc_sy), .acc_ss(acc_ss));

  // Theta divider
  logic        div_start, div_done;
  logic [31:0] div_quo;

  assign div_start = (state == S_DIV_GO);

  lbfgs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(rr), .den(dr),
    .done(div_done), .quo(div_quo));

  // Curvature test: pass when s'y > 0 and s'y > floor(eps * y'y / 2^32)
  logic [64:0] thr;
  logic        pass;

  assign thr  = {1'b0, p1} + {33'd0, prod[63:32]};
  assign pass = !dr[63] && (dr != '0) && ({1'b0, dr} > thr);

  // Ring update values
  logic [UW-1:0] uc_next;
  logic [HW:0]   t_sum;
  logic [HW-1:0] h_inc, n_inc;

  always_comb begin
    uc_next = (32'(update_count) < 32'(MAX_HISTORY + 1)) ?
              update_count + UW'(1) : update_count;
    t_sum   = (HW+1)'(hr) + (HW+1)'(uc_next) - (HW+1)'(1);
    if (t_sum >= (HW+1)'(m_eff)) begin
      t_sum = t_sum - (HW+1)'(m_eff);
    end
    h_inc = HW'(hr) + HW'(1);
    if (h_inc == m_eff) begin
      h_inc = '0;
    end
    n_inc = HW'(nr) + HW'(1);
    if (n_inc == m_eff) begin
      n_inc = '0;
    end
  end

  logic [HW-1:0] ptr_inc;
  assign ptr_inc = (HW'(ptr) + HW'(1) == m_eff) ? '0 : HW'(ptr) + HW'(1);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      element_count  <= '0;
      filled_columns <= '0;
      oldest_column  <= '0;
      newest_column  <= '0;
      update_count   <= '0;
      out_valid      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            sv            <= step_value;
            yv            <= grad_diff_value;
            last_el       <= is_last;
            element_count <= is_last ? '0 : element_count + IW'(1);
            state         <= S_EL_SY;
          end
        end
        S_EL_SY: state <= S_EL_SS;
        S_EL_SS: state <= last_el ? S_EL_WAIT : S_IDLE;
        S_EL_WAIT: state <= S_SNAP;
        S_SNAP: begin
          rr    <= acc_yy;
          dr    <= acc_sy;
          sss   <= acc_ss;
          state <= S_THR2;
        end
        S_THR2: begin
          p1    <= prod[63:0];
          state <= S_THR3;
        end
        S_THR3: begin
          if (pass) begin
            hr    <= oldest_column;
            nr    <= newest_column;
            state <= S_RED;
          end else begin
            accepted     <= 1'b0;
            theta        <= '0;
            row_position <= '0;
            sy_entry     <= '0;
            ss_entry     <= '0;
            last_result  <= 1'b1;
            out_valid    <= 1'b1;
            state        <= S_OUT;
          end
        end
        // Bring stale pointers below the current depth
        S_RED: begin
          if (HW'(hr) >= m_eff) begin
            hr <= PW'(HW'(hr) - m_eff);
          end
          if (HW'(nr) >= m_eff) begin
            nr <= PW'(HW'(nr) - m_eff);
          end
          if (HW'(hr) < m_eff && HW'(nr) < m_eff) begin
            state <= S_RING;
          end
        end
        S_RING: begin
          update_count <= uc_next;
          ci           <= '0;
          if (32'(uc_next) <= 32'(m_eff)) begin
            col            <= HW'(uc_next);
            filled_columns <= HW'(uc_next);
            tail           <= PW'(t_sum);
            newest_column  <= PW'(t_sum);
            oldest_column  <= hr;
            ptr            <= hr;
          end else begin
            tail          <= PW'(n_inc);
            newest_column <= PW'(n_inc);
            oldest_column <= PW'(h_inc);
            ptr           <= PW'(h_inc);
            if (filled_columns > m_eff) begin
              col            <= m_eff;
              filled_columns <= m_eff;
            end else if (filled_columns == '0) begin
              col            <= HW'(1);
              filled_columns <= HW'(1);
            end else begin
              col <= filled_columns;
            end
          end
          state <= S_COPY;
        end
        S_COPY: begin
          ci <= ci + LW'(1);
          if (ci == n_eff) begin
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            theta    <= div_quo;
            accepted <= 1'b1;
            j        <= '0;
            xi       <= '0;
            if (col > HW'(1)) begin
              state <= S_X_ADDR;
            end else begin
              row_position <= '0;
              sy_entry     <= dr;
              ss_entry     <= sss;
              last_result  <= 1'b1;
              out_valid    <= 1'b1;
              state        <= S_OUT;
            end
          end
        end
        S_X_ADDR: begin
          xi    <= '0;
          state <= S_X_MA;
        end
        S_X_MA: state <= S_X_MB;
        S_X_MB: begin
          if (xi + LW'(1) == n_eff) begin
            state <= S_X_DRAIN;
          end else begin
            xi    <= xi + LW'(1);
            state <= S_X_MA;
          end
        end
        S_X_DRAIN: state <= S_X_EMIT;
        S_X_EMIT: begin
          row_position <= 3'(j);
          sy_entry     <= acc_sy;
          ss_entry     <= acc_ss;
          last_result  <= 1'b0;
          out_valid    <= 1'b1;
          state        <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            if (last_result) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              j   <= j + HW'(1);
              ptr <= PW'(ptr_inc);
              if (j + HW'(2) < col) begin
                xi        <= '0;
                out_valid <= 1'b0;
                state     <= S_X_ADDR;
              end else begin
                row_position <= 3'(j + HW'(1));
                sy_entry     <= dr;
                ss_entry     <= sss;
                last_result  <= 1'b1;
                out_valid    <= 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/lbfgs_chk.sv */
// Port-level checker for the L-BFGS correction update core, with its bind.
module lbfgs_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        accepted,
  input logic [31:0] theta,
  input logic [2:0]  row_position,
  input logic [63:0] sy_entry,
  input logic        last_result
);

  // No request is taken while a result is pending
  a_no_take_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  // Each element request taken moves the sequencer out of idle, which raises in_stall
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block ready right after taking an element");

  // A rejected pair gives a single zeroed result
  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |->
      (last_result && theta == '0 && row_position == '0 && sy_entry == '0))
    else $error("malformed rejection result");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(theta) && $stable(sy_entry)))
    else $error("stalled result changed");

endmodule

bind limited_memory_bfgs_update_core lbfgs_chk u_lbfgs_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
  .theta(theta), .row_position(row_position), .sy_entry(sy_entry),
  .last_result(last_result));

/* test/limited_memory_bfgs_update_checker.sv */
// Checker for the L-BFGS correction update core: predicts each run and compares results.
`timescale 1ns / 100ps

module limited_memory_bfgs_update_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] step_value,
  input  logic signed [31:0] grad_diff_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               accepted,
  input  logic [31:0]        theta,
  input  logic [2:0]         row_position,
  input  logic signed [63:0] sy_entry,
  input  logic signed [63:0] ss_entry,
  input  logic               last_result,
  output int                 failures,
  output int                 pending
);

  localparam int HIST = 8;
  localparam int LEN  = 4096;

  typedef struct {
    logic        acc;
    logic [31:0] th;
    logic [2:0]  row;
    longint      sy;
    longint      ss;
    logic        last;
  } row_t;

  row_t row_queue[$];

  // Copy of the core's state
  logic [31:0] s_cols [0:LEN*HIST-1];
  logic [31:0] y_cols [0:LEN*HIST-1];
  logic [31:0] s_stage [0:LEN-1];
  logic [31:0] y_stage [0:LEN-1];
  longint ss_mat [0:HIST*HIST-1];
  longint sy_mat [0:HIST*HIST-1];
  longint yy_acc, sy_acc, ss_acc;
  int unsigned elem_cnt, filled, oldest, newest, updates;
  logic [12:0] vec_len;
  logic [3:0]  depth;
  logic [31:0] tol;

  function automatic longint clamp_add(longint a, longint b);
    longint hi, lo;
    hi = 64'sh7FFF_FFFF_FFFF_FFFF;
    lo = -hi - 1;
    if (b > 0 && a > hi - b) return hi;
    if (b < 0 && a < lo - b) return lo;
    return a + b;
  endfunction

  function automatic longint qmul(logic [31:0] a, logic [31:0] b);
    return longint'($signed(a)) * longint'($signed(b));
  endfunction

  // floor(rr * 2^16 / dr), saturated to 32 bits
  function automatic logic [31:0] theta_of(longint rr, longint dr);
    logic [79:0] q;
    q = {16'd0, rr[63:0]} << 16;
    q = q / {16'd0, dr[63:0]};
    return (q >= 80'h1_0000_0000) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  task automatic push_row(logic a, logic [31:0] t, logic [2:0] r, longint y, longint s,
                          logic l);
    row_t e;
    e.acc = a; e.th = t; e.row = r; e.sy = y; e.ss = s; e.last = l;
    row_queue.push_back(e);
  endtask

  // One element pair: stage, accumulate, and on the last element do the update
  task automatic take_pair(logic [31:0] sv, logic [31:0] yv);
    int unsigned n, m, idx, col, head, tail, j, i, ptr;
    longint rr, dr, sss, a, b;
    logic [95:0] prod;
    logic [63:0] thr;
    logic [31:0] th;
    n = (vec_len == 0) ? 1 : (vec_len > LEN ? LEN : vec_len);
    m = (depth == 0) ? 1 : (depth > HIST ? HIST : depth);
    idx = (elem_cnt < LEN) ? elem_cnt : LEN - 1;
    s_stage[idx] = sv;
    y_stage[idx] = yv;
    yy_acc = clamp_add(yy_acc, qmul(yv, yv));
    sy_acc = clamp_add(sy_acc, qmul(sv, yv));
    ss_acc = clamp_add(ss_acc, qmul(sv, sv));
    if (idx + 1 < n) begin
      elem_cnt = idx + 1;
      return;
    end
    elem_cnt = 0;
    rr = yy_acc; dr = sy_acc; sss = ss_acc;
    yy_acc = 0; sy_acc = 0; ss_acc = 0;

    // curvature test: reject when s'y <= 0 or s'y <= floor(eps * y'y / 2^32)
    prod = {64'd0, tol} * {32'd0, rr[63:0]};
    thr = prod[95:32];
    if (dr <= 0 || dr[63:0] <= thr) begin
      push_row(1'b0, 32'd0, 3'd0, 0, 0, 1'b1);
      return;
    end

    // ring bookkeeping
    if (updates < HIST + 1) updates++;
    head = oldest % m;
    col = filled;
    if (updates <= m) begin
      col = updates;
      tail = (head + updates - 1) % m;
    end else begin
      tail = (newest + 1) % m;
      head = (head + 1) % m;
      if (col > m) col = m;
      if (col < 1) col = 1;
    end
    filled = col; oldest = head; newest = tail;
    for (i = 0; i < n; i++) begin
      s_cols[i*HIST + tail] = s_stage[i];
      y_cols[i*HIST + tail] = y_stage[i];
    end
    th = theta_of(rr, dr);

    // drop the oldest pair from both matrices
    if (updates > m) begin
      for (j = 0; j + 1 < col; j++) begin
        for (i = 0; i < col - (j + 1); i++)
          ss_mat[j*HIST + j + i] = ss_mat[(j+1)*HIST + (j+1) + i];
        for (i = 0; i < j + 1; i++)
          sy_mat[j*HIST + i] = sy_mat[(j+1)*HIST + 1 + i];
      end
    end

    // new row of S'Y and new column of S'S
    ptr = head;
    for (j = 0; j + 1 < col; j++) begin
      a = 0; b = 0;
      for (i = 0; i < n; i++) begin
        a = clamp_add(a, qmul(s_stage[i], y_cols[i*HIST + ptr]));
        b = clamp_add(b, qmul(s_cols[i*HIST + ptr], s_stage[i]));
      end
      sy_mat[(col-1)*HIST + j] = a;
      ss_mat[j*HIST + col - 1] = b;
      ptr = (ptr + 1) % m;
    end
    sy_mat[(col-1)*HIST + col - 1] = dr;
    ss_mat[(col-1)*HIST + col - 1] = sss;

    for (j = 0; j < col; j++)
      push_row(1'b1, th, 3'(j), sy_mat[(col-1)*HIST + j], ss_mat[j*HIST + col - 1],
               j + 1 == col);
  endtask

  always @(posedge clk) begin
    row_t e;
    if (rst) begin
      row_queue.delete();
      yy_acc = 0; sy_acc = 0; ss_acc = 0;
      elem_cnt = 0; filled = 0; oldest = 0; newest = 0; updates = 0;
      vec_len = 13'd1; depth = 4'd8; tol = 32'd1;
      failures = 0;
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          lbfgs_pkg::REG_LENGTH:    vec_len = cfg_data[12:0];
          lbfgs_pkg::REG_DEPTH:     depth = cfg_data[3:0];
          lbfgs_pkg::REG_TOLERANCE: tol = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_pair(step_value, grad_diff_value);
      // compare a delivered result against the oldest prediction
      if (out_valid && !out_stall) begin
        if (row_queue.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: acc=%0b theta=%h row=%0d sy=%h ss=%h last=%0b",
                     accepted, theta, row_position, sy_entry, ss_entry, last_result);
        end else begin
          e = row_queue.pop_front();
          if (accepted !== e.acc || theta !== e.th || row_position !== e.row ||
              sy_entry !== e.sy || ss_entry !== e.ss || last_result !== e.last) begin
            failures++;
            if (failures <= 10) begin
              $display("mismatch exp: acc=%0b theta=%h row=%0d sy=%h ss=%h last=%0b",
                       e.acc, e.th, e.row, e.sy, e.ss, e.last);
              $display("         got: acc=%0b theta=%h row=%0d sy=%h ss=%h last=%0b",
                       accepted, theta, row_position, sy_entry, ss_entry, last_result);
            end
          end
        end
      end
    end
    pending = row_queue.size();
  end

endmodule

/* test/limited_memory_bfgs_update_core_test.sv */
// Testbench top for the L-BFGS correction update core: stimulus, idling and verdict.
`timescale 1ns / 100ps

module limited_memory_bfgs_update_core_test;

  localparam int LIMIT = 1000000;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] step_value;
  logic signed [31:0] grad_diff_value;
  logic               out_valid;
  logic               out_stall;
  logic               accepted;
  logic [31:0]        theta;
  logic [2:0]         row_position;
  logic signed [63:0] sy_entry;
  logic signed [63:0] ss_entry;
  logic               last_result;
  int                 failures;
  int                 pending;
  int                 cycles = 0;
  bit                 hold_req = 1'b0;

  limited_memory_bfgs_update_core uut (.*);

  limited_memory_bfgs_update_checker watch (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // receiver stalls, with one long hold-off on request
  initial begin
    int g;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (3000) @(negedge clk);
        hold_req = 1'b0;
        out_stall = 1'b0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          out_stall = 1'b1;
          repeat (g) @(negedge clk);
          out_stall = 1'b0;
        end
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
  end

  // offer one element pair and wait for its request to be taken
  task automatic send_pair(logic [31:0] s, logic [31:0] y);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid = 1'b1;
    step_value = s;
    grad_diff_value = y;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // wait until every result has come, plus a little for partial runs
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // kind 0: y close to s (likely kept), 1: unrelated words, 2: y = -s, 3: zeros
  task automatic send_vector(int n, int kind);
    logic [31:0] s, y;
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(0, 1 << 21);
      if ($urandom_range(0, 1)) s = -s;
      case (kind)
        0: y = s + $signed(32'($urandom_range(0, 4000)) - 32'sd2000);
        1: begin s = any_word(); y = any_word(); end
        2: y = -s;
        default: begin s = 0; y = 0; end
      endcase
      send_pair(s, y);
    end
  endtask

  initial begin
    int n;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = lbfgs_pkg::REG_LENGTH;
    cfg_data = 32'd0;
    in_valid = 1'b0;
    step_value = 32'sd0;
    grad_diff_value = 32'sd0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // full ring at length 8 before anything shorter; columns are then all written
    write_reg(lbfgs_pkg::REG_LENGTH, 32'd8);
    write_reg(lbfgs_pkg::REG_DEPTH, 32'd8);
    write_reg(lbfgs_pkg::REG_TOLERANCE, 32'd1);
    // extreme elements, saturating sums
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF);
    send_vector(4, 1);
    send_vector(8, 3);  // zero curvature is rejected
    send_vector(8, 2);  // negative curvature is rejected
    for (int r = 0; r < 11; r++) send_vector(8, 0);
    settle();

    // tolerance extremes
    write_reg(lbfgs_pkg::REG_TOLERANCE, 32'hFFFF_FFFF);
    for (int r = 0; r < 3; r++) send_vector(8, 0);
    settle();
    write_reg(lbfgs_pkg::REG_TOLERANCE, 32'd0);
    send_vector(8, 1);
    send_vector(8, 0);
    settle();

    // shallower ring, zero length acts as one
    write_reg(lbfgs_pkg::REG_DEPTH, 32'd5);
    write_reg(lbfgs_pkg::REG_LENGTH, 32'd0);
    for (int r = 0; r < 4; r++) send_vector(1, 0);
    settle();
    // length shrinks in the middle of a run
    write_reg(lbfgs_pkg::REG_LENGTH, 32'd8);
    send_vector(5, 0);
    settle();
    write_reg(lbfgs_pkg::REG_LENGTH, 32'd3);
    send_vector(1, 0);
    settle();

    // depth above the maximum, then random phases with one long receiver hold-off
    write_reg(lbfgs_pkg::REG_DEPTH, 32'd15);
    hold_req = 1'b1;
    for (int p = 0; p < 6; p++) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 8);
      write_reg(lbfgs_pkg::REG_LENGTH, n);
      if (p > 0) write_reg(lbfgs_pkg::REG_DEPTH, $urandom_range(2, 8));
      case ($urandom_range(0, 3))
        0: write_reg(lbfgs_pkg::REG_TOLERANCE, $urandom);
        1: write_reg(lbfgs_pkg::REG_TOLERANCE, $urandom_range(0, 1 << 24));
        default: write_reg(lbfgs_pkg::REG_TOLERANCE, 32'd1 << $urandom_range(0, 31));
      endcase
      if (n == 0) n = 1;
      for (int r = 0; r < 24 / n + 2; r++)
        send_vector(n, ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3));
      settle();
    end

    // single column from here on
    write_reg(lbfgs_pkg::REG_DEPTH, 32'd0);
    write_reg(lbfgs_pkg::REG_LENGTH, 32'd0);
    for (int r = 0; r < 6; r++) send_vector(1, $urandom_range(0, 2));
    settle();
    repeat (200) @(negedge clk);

    if (failures == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
